// ===== hdl/tgr_pkg.sv =====
`timescale 1ns / 1ps
// Package for the text glyph row rasterizer: word types, register map and
// font/cursor constants. No dependencies.
package tgr_pkg;

	// Register map of the configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BPP_MODE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CURSOR_COL   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CURSOR_ROW   = 3'd5;

	// Reset values
	localparam logic [47:0] RST_FRAME_BASE   = 48'd0;
	localparam logic [15:0] RST_LINE_PITCH   = 16'd2560;
	localparam logic [12:0] RST_SCREEN_WIDTH = 13'd640;
	localparam logic        RST_BPP_MODE     = 1'b1;
	localparam logic [9:0]  RST_CURSOR_COL   = 10'd0;
	localparam logic [8:0]  RST_CURSOR_ROW   = 9'd0;

	// Glyph geometry and special codes
	localparam logic [7:0]  BOX_FIRST       = 8'hB0;
	localparam logic [7:0]  BOX_LAST        = 8'hDF;
	localparam logic [3:0]  UNDERLINE_FIRST = 4'd14;
	localparam logic [14:0] GLYPH_W         = 15'd9;
	localparam logic [3:0]  COL_EIGHTH      = 4'd7;
	localparam logic [3:0]  COL_NINTH       = 4'd8;

	typedef struct packed {
		logic [9:0]  cell_col;
		logic [8:0]  cell_row;
		logic [3:0]  glyph_line;
		logic [7:0]  char_code;
		logic [7:0]  glyph_bits;
		logic [31:0] fg_color;
		logic [31:0] bg_color;
	} glyph_row_t;

	typedef struct packed {
		logic [47:0] pixel_addr;
		logic [31:0] pixel_color;
		logic        write_enable;
		logic        last_pixel;
	} pixel_t;

	typedef struct packed {
		logic [47:0] frame_base;
		logic [15:0] line_pitch;
		logic [12:0] screen_width;
		logic        bpp_mode;
		logic [9:0]  cursor_col;
		logic [8:0]  cursor_row;
	} cfg_t;

	// Prepared row handed from setup to the pixel sequencer
	typedef struct packed {
		logic [28:0] line_ofs;   // (row*16 + line) * pitch
		logic [15:0] col_ofs;    // col*9*bytes
		logic [8:0]  on_mask;    // bit 8 is column 0
		logic        ninth;
		logic [31:0] fg_color;
		logic [31:0] bg_color;
	} row_prep_t;

endpackage

// ===== hdl/tgr_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file of the glyph row rasterizer.
// Depends on tgr_pkg.
module tgr_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tgr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tgr_pkg::CFG_DATA_W-1:0] cfg_data,
	output tgr_pkg::cfg_t                  regs
);

	tgr_pkg::cfg_t regs_q;

	// Writes are always taken
	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	// Register decode; indexes past the map are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.frame_base   <= tgr_pkg::RST_FRAME_BASE;
			regs_q.line_pitch   <= tgr_pkg::RST_LINE_PITCH;
			regs_q.screen_width <= tgr_pkg::RST_SCREEN_WIDTH;
			regs_q.bpp_mode     <= tgr_pkg::RST_BPP_MODE;
			regs_q.cursor_col   <= tgr_pkg::RST_CURSOR_COL;
			regs_q.cursor_row   <= tgr_pkg::RST_CURSOR_ROW;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tgr_pkg::REG_FRAME_BASE:   regs_q.frame_base   <= cfg_data[47:0];
				tgr_pkg::REG_LINE_PITCH:   regs_q.line_pitch   <= cfg_data[15:0];
				tgr_pkg::REG_SCREEN_WIDTH: regs_q.screen_width <= cfg_data[12:0];
				tgr_pkg::REG_BPP_MODE:     regs_q.bpp_mode     <= cfg_data[0];
				tgr_pkg::REG_CURSOR_COL:   regs_q.cursor_col   <= cfg_data[9:0];
				tgr_pkg::REG_CURSOR_ROW:   regs_q.cursor_row   <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/tgr_setup.sv =====
`timescale 1ns / 1ps
// Row setup: input register, then line/column offsets, pixel mask and
// right-edge test into a second register. Depends on tgr_pkg.
module tgr_setup (
	input  logic                clk,
	input  logic                arst_n,
	input  tgr_pkg::cfg_t       regs,
	input  logic                item_valid,
	output logic                item_stall,
	input  tgr_pkg::glyph_row_t item,
	output logic                row_valid,
	input  logic                row_take,
	output tgr_pkg::row_prep_t  row
);

	logic                vld_s1;
	tgr_pkg::glyph_row_t item_s1;
	logic                vld_s2;
	tgr_pkg::row_prep_t  row_s2;

	logic                s2_free;
	logic                move_s1;
	logic                load_s1;
	logic [12:0]         line_idx;
	logic [13:0]         col9;
	logic                underline;
	logic                is_box;
	tgr_pkg::row_prep_t  prep;

	// Stage flow
	assign s2_free    = !vld_s2 || row_take;
	assign move_s1    = vld_s1 && s2_free;
	assign item_stall = vld_s1 && !s2_free;
	assign load_s1    = item_valid && !item_stall;

	// Offsets and mask of the row held in stage 1
	always_comb begin
		line_idx  = {item_s1.cell_row, item_s1.glyph_line};
		col9      = 14'({item_s1.cell_col, 3'b000}) + 14'(item_s1.cell_col);
		underline = (item_s1.cell_col == regs.cursor_col)
			&& (item_s1.cell_row == regs.cursor_row)
			&& (item_s1.glyph_line >= tgr_pkg::UNDERLINE_FIRST);
		is_box    = (item_s1.char_code >= tgr_pkg::BOX_FIRST)
			&& (item_s1.char_code <= tgr_pkg::BOX_LAST);

		prep.line_ofs = 29'(line_idx) * 29'(regs.line_pitch);
		prep.col_ofs  = regs.bpp_mode ? {col9, 2'b00}
			: 16'({col9, 1'b0}) + 16'(col9);
		prep.on_mask  = {item_s1.glyph_bits | {8{underline}},
			is_box && item_s1.glyph_bits[0]};
		prep.ninth    = (15'(col9) + tgr_pkg::GLYPH_W) <= 15'(regs.screen_width);
		prep.fg_color = item_s1.fg_color;
		prep.bg_color = item_s1.bg_color;
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				vld_s1 <= 1'b1;
			end else if (move_s1) begin
				vld_s1 <= 1'b0;
			end
			if (move_s1) begin
				vld_s2 <= 1'b1;
			end else if (row_take) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= item;
		end
		if (move_s1) begin
			row_s2 <= prep;
		end
	end

	assign row_valid = vld_s2;
	assign row       = row_s2;

	// A prepared row stays until the sequencer takes it
	a_row_held: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !row_take |=> vld_s2 && $stable(row_s2))
		else $error("prepared row lost before it was taken");

endmodule

// ===== hdl/tgr_emit.sv =====
`timescale 1ns / 1ps
// Pixel sequencer: holds one prepared row and sends its pixels, one word
// per unstalled cycle, stepping address and mask. Depends on tgr_pkg.
module tgr_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  tgr_pkg::cfg_t      regs,
	input  logic               row_valid,
	output logic               row_take,
	input  tgr_pkg::row_prep_t row,
	output logic               pix_valid,
	input  logic               pix_stall,
	output tgr_pkg::pixel_t    pix
);

	logic        busy_q;
	logic [3:0]  col_q;
	logic [47:0] addr_q;
	logic [8:0]  mask_q;
	logic        ninth_q;
	logic [31:0] fg_q;
	logic [31:0] bg_q;

	logic        send;
	logic        last;
	logic [31:0] chosen;
	logic [47:0] step;

	assign send     = busy_q && !pix_stall;
	assign last     = (col_q == tgr_pkg::COL_NINTH)
		|| ((col_q == tgr_pkg::COL_EIGHTH) && !ninth_q);
	assign row_take = row_valid && (!busy_q || (send && last));
	assign step     = regs.bpp_mode ? 48'd4 : 48'd3;

	// Output word from the held row
	always_comb begin
		chosen           = mask_q[8] ? fg_q : bg_q;
		pix.pixel_addr   = addr_q;
		pix.pixel_color  = regs.bpp_mode ? chosen : {8'h00, chosen[23:0]};
		pix.write_enable = |chosen[31:24];
		pix.last_pixel   = last;
	end
	assign pix_valid = busy_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= 4'd0;
		end else if (row_take) begin
			busy_q <= 1'b1;
			col_q  <= 4'd0;
		end else if (send) begin
			busy_q <= !last;
			col_q  <= col_q + 4'd1;
		end
	end

	// Row payload and pixel stepping
	always_ff @(posedge clk) begin
		if (row_take) begin
			addr_q  <= regs.frame_base + 48'(row.line_ofs) + 48'(row.col_ofs);
			mask_q  <= row.on_mask;
			ninth_q <= row.ninth;
			fg_q    <= row.fg_color;
			bg_q    <= row.bg_color;
		end else if (send) begin
			addr_q <= addr_q + step;
			mask_q <= {mask_q[7:0], 1'b0};
		end
	end

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> col_q <= tgr_pkg::COL_NINTH)
		else $error("column counter past the ninth column");

	a_no_early_last: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && col_q < tgr_pkg::COL_EIGHTH |-> !pix.last_pixel)
		else $error("last pixel flagged before column 7");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		send && last && !row_valid |=> !busy_q)
		else $error("sequencer still busy after the row's last pixel");

	a_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		send && last && row_valid |=> busy_q && col_q == 4'd0)
		else $error("next row not started right after last pixel");

endmodule

// ===== hdl/text_glyph_row_rasterizer.sv =====
`timescale 1ns / 1ps
// Rows pass the setup input, prepared-row and sequencer registers in turn.
// Each gives 9 pixel words, 8 when the ninth column is off screen, on the
// single output port, one word per cycle while pix_stall is low; rows follow
// with no gap. Reset (arst_n low, asynchronous) empties the pipeline and
// loads register defaults. Depends on tgr_pkg, tgr_cfg, tgr_setup, tgr_emit.
module text_glyph_row_rasterizer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tgr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tgr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  tgr_pkg::glyph_row_t            item,
	output logic                           pix_valid,
	input  logic                           pix_stall,
	output tgr_pkg::pixel_t                pix
);

	tgr_pkg::cfg_t      regs;
	logic               row_valid;
	logic               row_take;
	tgr_pkg::row_prep_t row;

	tgr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	tgr_setup u_setup (
		.clk        (clk),
		.arst_n     (arst_n),
		.regs       (regs),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.row_valid  (row_valid),
		.row_take   (row_take),
		.row        (row)
	);

	tgr_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.row_valid (row_valid),
		.row_take  (row_take),
		.row       (row),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix)
	);

endmodule

// ===== sim/tb_text_glyph_row_rasterizer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for text_glyph_row_rasterizer: drives glyph rows and
// register writes, predicts every pixel word and compares. Depends on tgr_pkg.
module tb_text_glyph_row_rasterizer;

	localparam int CYCLE_LIMIT    = 1000000;
	localparam int RANDOM_ROWS    = 60;
	localparam int RANDOM_PHASES  = 8;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 4;
	localparam int CELL_PIXELS    = 9;
	// Indexes past the register map; writes there must change nothing
	localparam logic [tgr_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [tgr_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// Predicts the pixel words of each row and checks them in order
	class pixel_scoreboard;
		tgr_pkg::cfg_t   regs;
		tgr_pkg::pixel_t expected_q[$];
		int     fails;
		int     rows;
		int     words;
		int     underline_rows;
		int     short_rows;
		int     disabled_words;
		int     settings;

		function new();
			regs.frame_base   = tgr_pkg::RST_FRAME_BASE;
			regs.line_pitch   = tgr_pkg::RST_LINE_PITCH;
			regs.screen_width = tgr_pkg::RST_SCREEN_WIDTH;
			regs.bpp_mode     = tgr_pkg::RST_BPP_MODE;
			regs.cursor_col   = tgr_pkg::RST_CURSOR_COL;
			regs.cursor_row   = tgr_pkg::RST_CURSOR_ROW;
			settings = 1;
		endfunction

		function void set_reg(logic [tgr_pkg::CFG_IDX_W-1:0] idx,
				logic [tgr_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				tgr_pkg::REG_FRAME_BASE:   regs.frame_base   = data[47:0];
				tgr_pkg::REG_LINE_PITCH:   regs.line_pitch   = data[15:0];
				tgr_pkg::REG_SCREEN_WIDTH: regs.screen_width = data[12:0];
				tgr_pkg::REG_BPP_MODE:     regs.bpp_mode     = data[0];
				tgr_pkg::REG_CURSOR_COL:   regs.cursor_col   = data[9:0];
				tgr_pkg::REG_CURSOR_ROW:   regs.cursor_row   = data[8:0];
				default: ;
			endcase
		endfunction

		// Expand one accepted glyph row into its 8 or 9 pixel words
		function void note_row(tgr_pkg::glyph_row_t r);
			logic [63:0] base;
			logic [31:0] color;
			tgr_pkg::pixel_t p;
			int          step;
			bit          underline;
			bit          ninth;
			bit          lit;
			step = regs.bpp_mode ? 4 : 3;
			underline = r.cell_col == regs.cursor_col && r.cell_row == regs.cursor_row &&
				r.glyph_line >= tgr_pkg::UNDERLINE_FIRST;
			ninth = (int'(r.cell_col) + 1) * int'(tgr_pkg::GLYPH_W)
				<= int'(regs.screen_width);
			// {row, line} is row*16 + line
			base = 64'(regs.frame_base)
				+ 64'({r.cell_row, r.glyph_line}) * 64'(regs.line_pitch)
				+ 64'(r.cell_col) * 64'(int'(tgr_pkg::GLYPH_W) * step);
			rows++;
			if (underline) underline_rows++;
			if (!ninth) short_rows++;
			for (int j = 0; j < CELL_PIXELS; j++) begin
				if (j == int'(tgr_pkg::COL_NINTH) && !ninth) break;
				if (j < int'(tgr_pkg::COL_NINTH))
					lit = r.glyph_bits[7 - j] || underline;
				else
					lit = r.char_code >= tgr_pkg::BOX_FIRST
						&& r.char_code <= tgr_pkg::BOX_LAST && r.glyph_bits[0];
				color = lit ? r.fg_color : r.bg_color;
				p.pixel_addr   = 48'(base + 64'(j * step));
				p.pixel_color  = regs.bpp_mode ? color : {8'h00, color[23:0]};
				p.write_enable = color[31:24] != 8'h00;
				p.last_pixel   = (j == int'(tgr_pkg::COL_NINTH))
					|| (j == int'(tgr_pkg::COL_EIGHTH) && !ninth);
				expected_q.push_back(p);
			end
		endfunction

		function void mismatch(string name, logic [63:0] exp_v, logic [63:0] act_v);
			fails++;
			$error("word %0d %s: expected %0h, got %0h", words, name, exp_v, act_v);
		endfunction

		function void check_pixel(tgr_pkg::pixel_t got);
			tgr_pkg::pixel_t exp_p;
			if (expected_q.size() == 0) begin
				fails++;
				$error("word %0d: unexpected pixel word addr %0h", words, got.pixel_addr);
				return;
			end
			exp_p = expected_q.pop_front();
			if (got.pixel_addr !== exp_p.pixel_addr)
				mismatch("pixel_addr", 64'(exp_p.pixel_addr), 64'(got.pixel_addr));
			if (got.pixel_color !== exp_p.pixel_color)
				mismatch("pixel_color", 64'(exp_p.pixel_color), 64'(got.pixel_color));
			if (got.write_enable !== exp_p.write_enable)
				mismatch("write_enable", 64'(exp_p.write_enable), 64'(got.write_enable));
			if (got.last_pixel !== exp_p.last_pixel)
				mismatch("last_pixel", 64'(exp_p.last_pixel), 64'(got.last_pixel));
			if (!exp_p.write_enable) disabled_words++;
			words++;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [tgr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [tgr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           item_valid = 1'b0;
	logic                           item_stall;
	tgr_pkg::glyph_row_t            glyph_row = '0;
	logic                           pix_valid;
	logic                           pix_stall = 1'b0;
	tgr_pkg::pixel_t                pixel;

	pixel_scoreboard sb = new();
	bit tx_idle;
	bit rx_idle;
	bit hold_req;
	int cycle_count;

	text_glyph_row_rasterizer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (glyph_row),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix        (pixel)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// Pixel receiver: random hold-offs per word, one long hold on request
	initial begin
		int gap;
		forever begin
			gap = rx_idle ? $urandom_range(0, 19) : 0;
			if (hold_req) begin
				gap = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (gap > 0) begin
				pix_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			pix_stall <= 1'b0;
			@(posedge clk);
			while (!pix_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pix_valid && !pix_stall)
			sb.check_pixel(pixel);
	end

	function automatic logic [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	// Keep the low w bits of v, random junk above them
	function automatic logic [47:0] with_junk(logic [47:0] v, int w);
		logic [47:0] keep;
		keep = (48'd1 << w) - 48'd1;
		return (rand48() & ~keep) | (v & keep);
	endfunction

	function automatic tgr_pkg::glyph_row_t mk_row(int col, int row, int line, int code,
			int bits, logic [31:0] fg, logic [31:0] bg);
		tgr_pkg::glyph_row_t r;
		r.cell_col   = 10'(col);
		r.cell_row   = 9'(row);
		r.glyph_line = 4'(line);
		r.char_code  = 8'(code);
		r.glyph_bits = 8'(bits);
		r.fg_color   = fg;
		r.bg_color   = bg;
		return r;
	endfunction

	// Random row biased toward the screen edge, the cursor cell and box codes
	function automatic tgr_pkg::glyph_row_t random_row();
		tgr_pkg::glyph_row_t r;
		int lim;
		int col;
		r.cell_row   = ($urandom_range(0, 1) == 0) ? 9'($urandom_range(0, 29)) : 9'($urandom);
		r.glyph_line = 4'($urandom);
		r.char_code  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range('hAE, 'hE1))
			: 8'($urandom);
		r.glyph_bits = 8'($urandom);
		r.fg_color   = $urandom;
		r.bg_color   = $urandom;
		if ($urandom_range(0, 5) == 0) r.fg_color[31:24] = 8'h00;
		if ($urandom_range(0, 5) == 0) r.bg_color[31:24] = 8'h00;
		case ($urandom_range(0, 3))
			0: begin
				lim = int'(sb.regs.screen_width) / int'(tgr_pkg::GLYPH_W);
				col = lim - 2 + $urandom_range(0, 3);
				if (col < 0) col = 0;
				if (col > 1023) col = 1023;
				r.cell_col = 10'(col);
			end
			1: r.cell_col = 10'($urandom_range(0, 79));
			default: r.cell_col = 10'($urandom);
		endcase
		if ($urandom_range(0, 7) == 0) begin
			r.cell_col   = sb.regs.cursor_col;
			r.cell_row   = sb.regs.cursor_row;
			r.glyph_line = 4'($urandom_range(12, 15));
		end
		return r;
	endfunction

	task automatic write_reg(input logic [tgr_pkg::CFG_IDX_W-1:0] idx,
			input logic [tgr_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(input logic [47:0] fb, input logic [47:0] pitch,
			input logic [47:0] width, input logic [47:0] bpp, input logic [47:0] ccol,
			input logic [47:0] crow);
		write_reg(tgr_pkg::REG_FRAME_BASE, fb);
		write_reg(tgr_pkg::REG_LINE_PITCH, pitch);
		write_reg(tgr_pkg::REG_SCREEN_WIDTH, width);
		write_reg(tgr_pkg::REG_BPP_MODE, bpp);
		write_reg(tgr_pkg::REG_CURSOR_COL, ccol);
		write_reg(tgr_pkg::REG_CURSOR_ROW, crow);
		sb.settings++;
	endtask

	task automatic send_row(input tgr_pkg::glyph_row_t r);
		int gap;
		gap = tx_idle ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		glyph_row  <= r;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sb.note_row(r);
	endtask

	// Let every expected word drain, then let the block settle
	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [47:0] width;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		hold_req = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: cursor at 0,0, 640 wide, 32-bit pixels
		send_row(mk_row(0, 0, 14, 'h41, 'h00, 32'hFF112233, 32'h80445566));
		send_row(mk_row(0, 0, 15, 'h41, 'h81, 32'hFF112233, 32'h80445566));
		send_row(mk_row(0, 0, 13, 'h41, 'h00, 32'hFF112233, 32'h80445566));
		send_row(mk_row(0, 1, 14, 'h41, 'h00, 32'hFF112233, 32'h80445566));
		send_row(mk_row(1, 0, 15, 'h41, 'h00, 32'hFF112233, 32'h80445566));
		send_row(mk_row(0, 0, 14, 'hDB, 'h01, 32'hFF00FF00, 32'h01000000));
		send_row(mk_row(5, 2, 3, 'hB0, 'h01, 32'hFFAA0000, 32'h20000055));
		send_row(mk_row(5, 2, 4, 'hDF, 'h01, 32'hFFAA0000, 32'h20000055));
		send_row(mk_row(5, 2, 5, 'hAF, 'h01, 32'hFFAA0000, 32'h20000055));
		send_row(mk_row(5, 2, 6, 'hE0, 'h01, 32'hFFAA0000, 32'h20000055));
		send_row(mk_row(5, 2, 7, 'hB0, 'hFE, 32'hFFAA0000, 32'h20000055));
		send_row(mk_row(6, 3, 0, 'h00, 'hFF, 32'hFFFFFFFF, 32'h00000000));
		send_row(mk_row(6, 3, 1, 'h00, 'h00, 32'hFFFFFFFF, 32'h00000000));
		send_row(mk_row(7, 4, 2, 'h58, 'hA5, 32'h00ABCDEF, 32'hFF123456));
		send_row(mk_row(7, 4, 9, 'h58, 'h5A, 32'hFF123456, 32'h00FFFFFF));
		send_row(mk_row(70, 29, 10, 'hC4, 'h01, 32'hFF0000FF, 32'hFF00FF00));
		send_row(mk_row(71, 29, 11, 'hC4, 'h01, 32'hFF0000FF, 32'hFF00FF00));
		send_row(mk_row(1023, 511, 15, 'hFF, 'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
		drain();

		// Upper extremes, 24-bit pixels: address wraps, cursor in the far corner
		write_all(48'hFFFF_FFFF_FFFF, 48'hFFFF, 48'd8191, 48'd0, 48'd1023, 48'd511);
		send_row(mk_row(1023, 511, 14, 'hB3, 'h00, 32'hFF808080, 32'h7F010203));
		send_row(mk_row(1023, 511, 15, 'hB3, 'h01, 32'h00808080, 32'hFF010203));
		send_row(mk_row(909, 511, 15, 'hB3, 'h01, 32'hFFC0C0C0, 32'hFF010203));
		send_row(mk_row(910, 511, 15, 'hB3, 'h01, 32'hFFC0C0C0, 32'hFF010203));
		send_row(mk_row(0, 0, 0, 'h20, 'h00, 32'hFFFFFFFF, 32'h00FFFFFF));

		for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
			drain();
			if (ph == 2) begin
				// Lower extremes: nothing fits, every row drops the ninth column
				write_all(48'd0, 48'd0, 48'd0, 48'd1, 48'd0, 48'd0);
			end else if (ph > 2) begin
				case ($urandom_range(0, 4))
					0: width = 48'd640;
					1: width = 48'd720;
					2: width = 48'd1024;
					3: width = 48'd1920;
					default: width = 48'($urandom_range(0, 8191));
				endcase
				write_all(rand48(), rand48(), with_junk(width, 13), rand48(),
					with_junk(48'($urandom_range(0, 79)), 10),
					with_junk(48'($urandom_range(0, 29)), 9));
				if (ph == 3) begin
					write_reg(REG_SPARE_LO, rand48());
					write_reg(REG_SPARE_HI, rand48());
				end
			end
			tx_idle = ph[0];
			rx_idle = ph[1];
			// Long output hold-off with a back-to-back sender fills the block
			if (ph == 4) hold_req = 1'b1;
			for (int i = 0; i < RANDOM_ROWS; i++)
				send_row(random_row());
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.fails++;
			$error("%0d pixel words never arrived", sb.pending());
		end
		$display("covered %0d glyph rows and %0d pixel words over %0d register settings",
			sb.rows, sb.words, sb.settings);
		$display("%0d cursor underline rows, %0d rows clipped at the edge, %0d disabled writes",
			sb.underline_rows, sb.short_rows, sb.disabled_words);
		if (sb.fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
